>>> src/lrd_pkg.sv
// lrd_pkg: shared constants, types and tables of the lidar ray direction unit
// used by the division cell, the cordic cell, the top level and the checker
`timescale 1ns / 1ps

package lrd_pkg;

  // limits of the scan configuration
  localparam int MAX_AZIMUTH_STEPS = 4096;
  localparam int CHANNELS          = 16;

  // port widths
  localparam int AZ_INDEX_W  = 12;
  localparam int CH_INDEX_W  = 4;
  localparam int STEPS_W     = 13;
  localparam int CHAN_CNT_W  = 5;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int DIR_W       = 16;
  localparam int ERR_W       = 2;
  localparam int ELEV_W      = 16;
  localparam int ELEV_REGS   = 4;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_AZIMUTH_STEPS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEV_ANGLES_0 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEV_ANGLES_1 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEV_ANGLES_2 = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_ELEV_ANGLES_3 = 3'd5;

  // reset values of the configuration
  localparam logic [STEPS_W-1:0]    AZIMUTH_STEPS_RST = 13'd1024;
  localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RST = 5'd16;

  // azimuth divider: remainder as wide as the divisor, one quotient bit per cell
  localparam int DIV_W      = STEPS_W;
  localparam int QUOT_W     = 23;
  localparam int DIVIDEND_W = 35;
  localparam int DIV_STEPS  = QUOT_W;
  localparam logic [QUOT_W-1:0] TWO_PI_STEP = 23'd6588398;

  // angles in signed q.20 radians
  localparam int ANGLE_W = 24;
  localparam logic signed [ANGLE_W-1:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [ANGLE_W-1:0] TWO_PI_Q20  = 24'sd6588398;
  localparam int ELEV_SHIFT = 7;

  // cordic rotation chain on signed q.30 values
  localparam int CORDIC_W     = 32;
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = 5;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032875;

  localparam logic signed [ANGLE_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
    24'sd823550, 24'sd486170, 24'sd256879, 24'sd130396, 24'sd65451,
    24'sd32757,  24'sd16383,  24'sd8192,   24'sd4096,   24'sd2048,
    24'sd1024,   24'sd512,    24'sd256,    24'sd128,    24'sd64,
    24'sd32,     24'sd16,     24'sd8,      24'sd4,      24'sd2
  };

  // output scaling
  localparam int PROD_W     = 2 * CORDIC_W;
  localparam int XY_SHIFT   = 45;
  localparam int Z_SHIFT    = 15;
  localparam int RND_W      = PROD_W - XY_SHIFT;

  // request to result, in cycles
  localparam int LATENCY = DIV_STEPS + CORDIC_STEPS + 8;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE    = 2'd0,
    ERR_AZIMUTH = 2'd1,
    ERR_CHANNEL = 2'd2
  } err_t;

  // one slot of the divider chain
  typedef struct packed {
    logic              valid;
    err_t              err;
    logic [ELEV_W-1:0] el_raw;
    logic [DIV_W-1:0]  rem;
    logic [QUOT_W-1:0] word;
  } div_stage_t;

  // one rotation in flight
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  a;
    logic                       neg;
  } rot_t;

  // one slot of the cordic chain, azimuth and elevation side by side
  typedef struct packed {
    logic valid;
    err_t err;
    rot_t az;
    rot_t el;
  } cordic_stage_t;

endpackage

>>> src/lrd_div_cell.sv
// lrd_div_cell: one restoring division step of the azimuth divider chain
// depends on lrd_pkg
`timescale 1ns / 1ps

module lrd_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lrd_pkg::DIV_W-1:0]     divisor,
  input  lrd_pkg::div_stage_t           din,
  output lrd_pkg::div_stage_t           dout
);

  logic [lrd_pkg::DIV_W:0]   rem_shift;
  logic [lrd_pkg::DIV_W:0]   rem_diff;
  logic                      fits;
  lrd_pkg::div_stage_t       dout_next;

  // bring down the next dividend bit and try the subtraction
  always_comb begin
    rem_shift = {din.rem, din.word[lrd_pkg::QUOT_W-1]};
    rem_diff  = rem_shift - {1'b0, divisor};
    fits      = (rem_shift >= {1'b0, divisor});
    dout_next = din;
    dout_next.rem  = fits ? rem_diff[lrd_pkg::DIV_W-1:0] : rem_shift[lrd_pkg::DIV_W-1:0];
    dout_next.word = {din.word[lrd_pkg::QUOT_W-2:0], fits};
  end

  // hand the slot on to the next cell
  always_ff @(posedge clk) begin
    dout <= dout_next;
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

>>> src/lrd_cordic_cell.sv
// lrd_cordic_cell: one cordic rotation step for both azimuth and elevation
// depends on lrd_pkg (rotation types and arctangent table)
`timescale 1ns / 1ps

module lrd_cordic_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [lrd_pkg::STEP_W-1:0]    step,
  input  lrd_pkg::cordic_stage_t        din,
  output lrd_pkg::cordic_stage_t        dout
);

  lrd_pkg::cordic_stage_t dout_next;

  // rotate toward zero residual angle by atan(2^-i)
  function automatic lrd_pkg::rot_t rotate(input lrd_pkg::rot_t r,
                                           input logic [lrd_pkg::STEP_W-1:0] i);
    lrd_pkg::rot_t                       o;
    logic signed [lrd_pkg::CORDIC_W-1:0] xs;
    logic signed [lrd_pkg::CORDIC_W-1:0] ys;
    logic signed [lrd_pkg::ANGLE_W-1:0]  ang;
    xs    = r.x;
    ys    = r.y;
    ang   = lrd_pkg::ATAN_Q20[i];
    o     = r;
    if (!r.a[lrd_pkg::ANGLE_W-1]) begin
      o.x = xs - (ys >>> i);
      o.y = ys + (xs >>> i);
      o.a = r.a - ang;
    end else begin
      o.x = xs + (ys >>> i);
      o.y = ys - (xs >>> i);
      o.a = r.a + ang;
    end
    return o;
  endfunction

  always_comb begin
    dout_next    = din;
    dout_next.az = rotate(din.az, step);
    dout_next.el = rotate(din.el, step);
  end

  // hand the slot on to the next cell
  always_ff @(posedge clk) begin
    dout <= dout_next;
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

>>> src/lidar_ray_direction_unit.sv
// lidar ray direction unit: one request per cycle, the result passing through 23 divider cells
// for the azimuth angle, 20 cordic cells and 8 staging registers.
// throughput: one request every cycle, busy only while rst is high.
// the result strobe done lasts one cycle and cannot be held off by the receiver.
// reset restores the default configuration and drops every request in flight.
// depends on lrd_pkg, lrd_div_cell and lrd_cordic_cell
`timescale 1ns / 1ps

module lidar_ray_direction_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lrd_pkg::AZ_INDEX_W-1:0]      azimuth_index,
  input  logic [lrd_pkg::CH_INDEX_W-1:0]      channel_index,
  input  logic                                cfg_write,
  input  logic [lrd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lrd_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                done,
  output logic signed [lrd_pkg::DIR_W-1:0]    dir_x,
  output logic signed [lrd_pkg::DIR_W-1:0]    dir_y,
  output logic signed [lrd_pkg::DIR_W-1:0]    dir_z,
  output logic [lrd_pkg::ERR_W-1:0]           error_code
);

  // configuration registers
  logic [lrd_pkg::STEPS_W-1:0]    az_step_count;
  logic [lrd_pkg::CHAN_CNT_W-1:0] channel_count;
  logic [lrd_pkg::CFG_DATA_W-1:0] elev_angles [lrd_pkg::ELEV_REGS];

  logic [lrd_pkg::STEPS_W-1:0]    steps_eff;
  logic [lrd_pkg::CHAN_CNT_W-1:0] chans_eff;

  // request stage
  logic                           accept;
  lrd_pkg::err_t                  in_err;
  logic [lrd_pkg::ELEV_W-1:0]     in_el_raw;
  logic                           s0_valid;
  lrd_pkg::err_t                  s0_err;
  logic [lrd_pkg::AZ_INDEX_W-1:0] s0_az_index;
  logic [lrd_pkg::ELEV_W-1:0]     s0_el_raw;

  // dividend stage and divider chain
  logic [lrd_pkg::DIVIDEND_W-1:0] dividend;
  lrd_pkg::div_stage_t            s1;
  lrd_pkg::div_stage_t            s1_next;
  lrd_pkg::div_stage_t            div_pipe [lrd_pkg::DIV_STEPS+1];

  // angle wrapping stages
  logic signed [lrd_pkg::ANGLE_W-1:0] az_angle;
  logic signed [lrd_pkg::ANGLE_W-1:0] el_angle;
  logic                               w1_valid;
  lrd_pkg::err_t                      w1_err;
  logic signed [lrd_pkg::ANGLE_W-1:0] w1_az;
  logic signed [lrd_pkg::ANGLE_W-1:0] w1_el;
  lrd_pkg::cordic_stage_t             w2;
  lrd_pkg::cordic_stage_t             w2_next;
  lrd_pkg::cordic_stage_t             cordic_pipe [lrd_pkg::CORDIC_STEPS+1];
  lrd_pkg::cordic_stage_t             cordic_last;

  // sign fix, products, magnitudes
  logic                                n_valid;
  lrd_pkg::err_t                       n_err;
  logic signed [lrd_pkg::CORDIC_W-1:0] n_ca;
  logic signed [lrd_pkg::CORDIC_W-1:0] n_sa;
  logic signed [lrd_pkg::CORDIC_W-1:0] n_ce;
  logic signed [lrd_pkg::CORDIC_W-1:0] n_se;
  logic                                m_valid;
  lrd_pkg::err_t                       m_err;
  logic signed [lrd_pkg::PROD_W-1:0]   m_px;
  logic signed [lrd_pkg::PROD_W-1:0]   m_py;
  logic signed [lrd_pkg::CORDIC_W-1:0] m_z;
  logic                                a_valid;
  lrd_pkg::err_t                       a_err;
  logic [lrd_pkg::PROD_W-1:0]          a_mag_x;
  logic [lrd_pkg::PROD_W-1:0]          a_mag_y;
  logic [lrd_pkg::CORDIC_W-1:0]        a_mag_z;
  logic                                a_neg_x;
  logic                                a_neg_y;
  logic                                a_neg_z;

  // rounding
  logic [lrd_pkg::PROD_W-1:0]          sum_x;
  logic [lrd_pkg::PROD_W-1:0]          sum_y;
  logic [lrd_pkg::CORDIC_W-1:0]        sum_z;
  logic [lrd_pkg::RND_W-1:0]           rnd_x;
  logic [lrd_pkg::RND_W-1:0]           rnd_y;
  logic [lrd_pkg::RND_W-1:0]           rnd_z;

  // wrap an angle into one turn around zero
  function automatic logic signed [lrd_pkg::ANGLE_W-1:0] wrap_turn(
    input logic signed [lrd_pkg::ANGLE_W-1:0] a);
    logic signed [lrd_pkg::ANGLE_W-1:0] r;
    r = a;
    if (r > lrd_pkg::PI_Q20) begin
      r = r - lrd_pkg::TWO_PI_Q20;
    end
    if (r < -lrd_pkg::PI_Q20) begin
      r = r + lrd_pkg::TWO_PI_Q20;
    end
    return r;
  endfunction

  // fold into the right half plane and seed the rotation
  function automatic lrd_pkg::rot_t fold_half(input logic signed [lrd_pkg::ANGLE_W-1:0] a);
    lrd_pkg::rot_t r;
    r.x   = lrd_pkg::CORDIC_GAIN_Q30;
    r.y   = '0;
    r.a   = a;
    r.neg = 1'b0;
    if (a > lrd_pkg::HALF_PI_Q20) begin
      r.a   = a - lrd_pkg::PI_Q20;
      r.neg = 1'b1;
    end else if (a < -lrd_pkg::HALF_PI_Q20) begin
      r.a   = a + lrd_pkg::PI_Q20;
      r.neg = 1'b1;
    end
    return r;
  endfunction

  // clamp a rounded magnitude into q1.15 with its sign
  function automatic logic signed [lrd_pkg::DIR_W-1:0] saturate(
    input logic [lrd_pkg::RND_W-1:0] mag, input logic neg);
    logic signed [lrd_pkg::RND_W:0] t;
    logic signed [lrd_pkg::DIR_W-1:0] r;
    t = -$signed({1'b0, mag});
    if (neg) begin
      if (mag > lrd_pkg::RND_W'(32768)) begin
        r = 16'sh8000;
      end else begin
        r = t[lrd_pkg::DIR_W-1:0];
      end
    end else begin
      if (mag > lrd_pkg::RND_W'(32767)) begin
        r = 16'sh7fff;
      end else begin
        r = mag[lrd_pkg::DIR_W-1:0];
      end
    end
    return r;
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      az_step_count <= lrd_pkg::AZIMUTH_STEPS_RST;
      channel_count <= lrd_pkg::CHANNEL_COUNT_RST;
      for (int i = 0; i < lrd_pkg::ELEV_REGS; i++) begin
        elev_angles[i] <= '0;
      end
    end else if (cfg_write) begin
      case (cfg_index)
        lrd_pkg::REG_AZIMUTH_STEPS: az_step_count  <= cfg_data[lrd_pkg::STEPS_W-1:0];
        lrd_pkg::REG_CHANNEL_COUNT: channel_count  <= cfg_data[lrd_pkg::CHAN_CNT_W-1:0];
        lrd_pkg::REG_ELEV_ANGLES_0: elev_angles[0] <= cfg_data;
        lrd_pkg::REG_ELEV_ANGLES_1: elev_angles[1] <= cfg_data;
        lrd_pkg::REG_ELEV_ANGLES_2: elev_angles[2] <= cfg_data;
        lrd_pkg::REG_ELEV_ANGLES_3: elev_angles[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // counts in use, clamped to the built limits
  assign steps_eff = (az_step_count > lrd_pkg::STEPS_W'(lrd_pkg::MAX_AZIMUTH_STEPS)) ?
                     lrd_pkg::STEPS_W'(lrd_pkg::MAX_AZIMUTH_STEPS) : az_step_count;
  assign chans_eff = (channel_count > lrd_pkg::CHAN_CNT_W'(lrd_pkg::CHANNELS)) ?
                     lrd_pkg::CHAN_CNT_W'(lrd_pkg::CHANNELS) : channel_count;

  // range checks and elevation lookup on the request
  always_comb begin
    if ({1'b0, azimuth_index} >= steps_eff) begin
      in_err = lrd_pkg::ERR_AZIMUTH;
    end else if ({1'b0, channel_index} >= chans_eff) begin
      in_err = lrd_pkg::ERR_CHANNEL;
    end else begin
      in_err = lrd_pkg::ERR_NONE;
    end
    in_el_raw = elev_angles[channel_index[3:2]][{channel_index[1:0], 4'b0000} +: lrd_pkg::ELEV_W];
  end

  always_ff @(posedge clk) begin
    s0_valid    <= accept;
    s0_err      <= in_err;
    s0_az_index <= azimuth_index;
    s0_el_raw   <= in_el_raw;
    if (rst) begin
      s0_valid <= 1'b0;
    end
  end

  // scaled azimuth plus half the step count, split for the divider
  always_comb begin
    dividend = lrd_pkg::DIVIDEND_W'(s0_az_index) * lrd_pkg::DIVIDEND_W'(lrd_pkg::TWO_PI_STEP)
             + lrd_pkg::DIVIDEND_W'(steps_eff[lrd_pkg::STEPS_W-1:1]);
    s1_next.valid  = s0_valid;
    s1_next.err    = s0_err;
    s1_next.el_raw = s0_el_raw;
    s1_next.rem    = lrd_pkg::DIV_W'(dividend[lrd_pkg::DIVIDEND_W-1:lrd_pkg::QUOT_W]);
    s1_next.word   = dividend[lrd_pkg::QUOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    s1 <= s1_next;
    if (rst) begin
      s1.valid <= 1'b0;
    end
  end

  // divider chain, one quotient bit per cell
  assign div_pipe[0] = s1;

  for (genvar k = 0; k < lrd_pkg::DIV_STEPS; k++) begin : g_div
    lrd_div_cell u_div_cell (
      .clk     (clk),
      .rst     (rst),
      .divisor (steps_eff),
      .din     (div_pipe[k]),
      .dout    (div_pipe[k+1])
    );
  end

  // angles in q.20, wrapped into one turn
  always_comb begin
    az_angle = $signed({1'b0, div_pipe[lrd_pkg::DIV_STEPS].word});
    el_angle = $signed({div_pipe[lrd_pkg::DIV_STEPS].el_raw[lrd_pkg::ELEV_W-1],
                        div_pipe[lrd_pkg::DIV_STEPS].el_raw,
                        lrd_pkg::ELEV_SHIFT'(0)});
  end

  always_ff @(posedge clk) begin
    w1_valid <= div_pipe[lrd_pkg::DIV_STEPS].valid;
    w1_err   <= div_pipe[lrd_pkg::DIV_STEPS].err;
    w1_az    <= wrap_turn(az_angle);
    w1_el    <= wrap_turn(el_angle);
    if (rst) begin
      w1_valid <= 1'b0;
    end
  end

  // fold into the right half plane
  always_comb begin
    w2_next.valid = w1_valid;
    w2_next.err   = w1_err;
    w2_next.az    = fold_half(w1_az);
    w2_next.el    = fold_half(w1_el);
  end

  always_ff @(posedge clk) begin
    w2 <= w2_next;
    if (rst) begin
      w2.valid <= 1'b0;
    end
  end

  // cordic chain
  assign cordic_pipe[0] = w2;

  for (genvar k = 0; k < lrd_pkg::CORDIC_STEPS; k++) begin : g_cordic
    lrd_cordic_cell u_cordic_cell (
      .clk  (clk),
      .rst  (rst),
      .step (lrd_pkg::STEP_W'(k)),
      .din  (cordic_pipe[k]),
      .dout (cordic_pipe[k+1])
    );
  end

  assign cordic_last = cordic_pipe[lrd_pkg::CORDIC_STEPS];

  // undo the half-plane fold
  always_ff @(posedge clk) begin
    n_valid <= cordic_last.valid;
    n_err   <= cordic_last.err;
    n_ca    <= cordic_last.az.neg ? -cordic_last.az.x : cordic_last.az.x;
    n_sa    <= cordic_last.az.neg ? -cordic_last.az.y : cordic_last.az.y;
    n_ce    <= cordic_last.el.neg ? -cordic_last.el.x : cordic_last.el.x;
    n_se    <= cordic_last.el.neg ? -cordic_last.el.y : cordic_last.el.y;
    if (rst) begin
      n_valid <= 1'b0;
    end
  end

  // horizontal components scaled by cos(el)
  always_ff @(posedge clk) begin
    m_valid <= n_valid;
    m_err   <= n_err;
    m_px    <= lrd_pkg::PROD_W'(n_ce) * lrd_pkg::PROD_W'(n_ca);
    m_py    <= lrd_pkg::PROD_W'(n_ce) * lrd_pkg::PROD_W'(n_sa);
    m_z     <= n_se;
    if (rst) begin
      m_valid <= 1'b0;
    end
  end

  // sign and magnitude for symmetric rounding
  always_ff @(posedge clk) begin
    a_valid <= m_valid;
    a_err   <= m_err;
    a_neg_x <= m_px[lrd_pkg::PROD_W-1];
    a_neg_y <= m_py[lrd_pkg::PROD_W-1];
    a_neg_z <= m_z[lrd_pkg::CORDIC_W-1];
    a_mag_x <= m_px[lrd_pkg::PROD_W-1] ? $unsigned(-m_px) : $unsigned(m_px);
    a_mag_y <= m_py[lrd_pkg::PROD_W-1] ? $unsigned(-m_py) : $unsigned(m_py);
    a_mag_z <= m_z[lrd_pkg::CORDIC_W-1] ? $unsigned(-m_z) : $unsigned(m_z);
    if (rst) begin
      a_valid <= 1'b0;
    end
  end

  // round half away from zero
  always_comb begin
    sum_x = a_mag_x + (lrd_pkg::PROD_W'(1) << (lrd_pkg::XY_SHIFT - 1));
    sum_y = a_mag_y + (lrd_pkg::PROD_W'(1) << (lrd_pkg::XY_SHIFT - 1));
    sum_z = a_mag_z + (lrd_pkg::CORDIC_W'(1) << (lrd_pkg::Z_SHIFT - 1));
    rnd_x = sum_x[lrd_pkg::PROD_W-1:lrd_pkg::XY_SHIFT];
    rnd_y = sum_y[lrd_pkg::PROD_W-1:lrd_pkg::XY_SHIFT];
    rnd_z = lrd_pkg::RND_W'(sum_z[lrd_pkg::CORDIC_W-1:lrd_pkg::Z_SHIFT]);
  end

  // result registers, zero direction on a range error
  always_ff @(posedge clk) begin
    done       <= a_valid;
    error_code <= a_err;
    if (a_err == lrd_pkg::ERR_NONE) begin
      dir_x <= saturate(rnd_x, a_neg_x);
      dir_y <= saturate(rnd_y, a_neg_y);
      dir_z <= saturate(rnd_z, a_neg_z);
    end else begin
      dir_x <= '0;
      dir_y <= '0;
      dir_z <= '0;
    end
    if (rst) begin
      done <= 1'b0;
    end
  end

endmodule

>>> src/lrd_checker.sv
// lrd_checker: port-level checks of the lidar ray direction unit, bound to the top level
// depends on lrd_pkg and lidar_ray_direction_unit
`timescale 1ns / 1ps

module lrd_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                start,
  input logic                                busy,
  input logic                                done,
  input logic signed [lrd_pkg::DIR_W-1:0]    dir_x,
  input logic signed [lrd_pkg::DIR_W-1:0]    dir_y,
  input logic signed [lrd_pkg::DIR_W-1:0]    dir_z,
  input logic [lrd_pkg::ERR_W-1:0]           error_code
);

  // a failed range check gives a zero direction
  a_err_zero_dir: assert property (@(posedge clk) disable iff (rst)
    done && (error_code != lrd_pkg::ERR_NONE) |-> (dir_x == 0) && (dir_y == 0) && (dir_z == 0))
    else $error("range error with nonzero direction");

  // a good ray is never the zero vector
  a_unit_nonzero: assert property (@(posedge clk) disable iff (rst)
    done && (error_code == lrd_pkg::ERR_NONE) |-> (dir_x != 0) || (dir_y != 0) || (dir_z != 0))
    else $error("valid ray with zero direction");

  // every result traces back to a request a fixed latency earlier
  a_done_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, lrd_pkg::LATENCY))
    else $error("result without a matching request");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result right after reset");

endmodule

bind lidar_ray_direction_unit lrd_checker u_lrd_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .dir_x      (dir_x),
  .dir_y      (dir_y),
  .dir_z      (dir_z),
  .error_code (error_code)
);
